FILE: hdl/uerg_pkg.sv
// Package: shared widths and constants for the ultrasonic echo range gate.
package uerg_pkg;

	localparam int TIME_W   = 32;
	localparam int DT_W     = 16;
	localparam int DIST_W   = 15;
	localparam int VAR_W    = 28;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 28;

	// Elapsed time saturates at this many microseconds
	localparam logic [DT_W-1:0] DT_MAX = 16'hFFFF;

	// Distance scale: dist_q4 = floor(dt * 343 / 1250)
	localparam int MUL_W = 9;
	localparam logic [MUL_W-1:0] DIST_MUL = 9'd343;
	localparam int PROD1_W = DT_W + MUL_W;

	// Reciprocal of 1250, rounded up, scaled by 2^36; exact for products below 2^25
	localparam int RECIP_W     = 26;
	localparam int RECIP_SHIFT = 36;
	localparam logic [RECIP_W-1:0] DIST_RECIP = 26'd54975582;
	localparam int PROD2_W = PROD1_W + RECIP_W;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MIN_DISTANCE   = 1'b0,
		CFG_VARIANCE_LIMIT = 1'b1
	} cfg_idx_t;

	localparam logic [DIST_W-1:0] MIN_DIST_RST  = 15'd0;
	localparam logic [VAR_W-1:0]  VAR_LIMIT_RST = 28'd2560;

endpackage

FILE: hdl/ultrasonic_echo_range_gate.sv
// Top level: echo edge timing, distance ring in memory, sample variance and alert gate.
// Rising edge: accepted, start time captured, no result. Falling edge: runs S_MUL1, S_MUL2,
// S_DIST, S_UPD1, S_UPD2, S_MULN, S_PREP, S_DIV, then S_OUT, and the next item is taken once
// the result is loaded; the restoring divider gives one quotient bit per cycle, NUM_W bits.
// A result waits in the output register while the next item is taken and processed.
// Reset (arst_n low) clears start time, pointer, count, sums, registers to their defaults;
// the history memory holds no reset and needs no clearing pass.
module ultrasonic_echo_range_gate #(
	parameter int HISTORY_DEPTH = 10
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [uerg_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [uerg_pkg::CFG_DAT_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              echo_level,
	input  logic [uerg_pkg::TIME_W-1:0]       time_us,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [uerg_pkg::DIST_W-1:0]       distance_q4,
	output logic [uerg_pkg::VAR_W-1:0]        variance_q8,
	output logic                              near_alert,
	output logic                              near_ignored
);

	localparam int PTR_W  = (HISTORY_DEPTH > 2) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
	localparam int SUM_W  = uerg_pkg::DIST_W + CNT_W;
	localparam int SQ_W   = 2 * uerg_pkg::DIST_W + CNT_W;
	localparam int NUM_W  = SQ_W + CNT_W;
	localparam int DEN_W  = 2 * CNT_W;
	localparam int DCNT_W = $clog2(NUM_W);
	localparam int DSQ_W  = 2 * uerg_pkg::DIST_W;

	typedef enum logic [3:0] {
		S_IDLE, S_MUL1, S_MUL2, S_DIST, S_UPD1, S_UPD2, S_MULN, S_PREP, S_DIV, S_OUT
	} state_t;

	state_t state_q;

	logic [uerg_pkg::DIST_W-1:0]  min_dist_q;
	logic [uerg_pkg::VAR_W-1:0]   var_limit_q;
	logic [uerg_pkg::TIME_W-1:0]  start_q;
	logic [uerg_pkg::DT_W-1:0]    dt_q;
	logic [uerg_pkg::PROD1_W-1:0] prod1_q;
	logic [uerg_pkg::PROD2_W-1:0] prod2_q;
	logic [uerg_pkg::DIST_W-1:0]  dist_q;
	logic [uerg_pkg::DIST_W-1:0]  old_q;
	logic [DSQ_W-1:0]             new_sq_q;
	logic [DSQ_W-1:0]             old_sq_q;
	logic                         full_q;
	logic [PTR_W-1:0]             wr_ptr_q;
	logic [CNT_W-1:0]             cnt_q;
	logic [SUM_W-1:0]             sum_q;
	logic [SQ_W-1:0]              sq_q;
	logic [NUM_W-1:0]             n_sq_q;
	logic [NUM_W-1:0]             s_sq_q;
	logic [NUM_W-1:0]             num_q;
	logic [DEN_W-1:0]             den_q;
	logic [DEN_W-1:0]             rem_q;
	logic [DCNT_W-1:0]            div_cnt_q;
	logic                         var_zero_q;

	logic [uerg_pkg::DIST_W-1:0]  hist_mem [HISTORY_DEPTH];

	logic [uerg_pkg::TIME_W-1:0]  elapsed;
	logic [uerg_pkg::DT_W-1:0]    dt_sat;
	logic [DEN_W:0]               trial;
	logic                         trial_ge;
	logic [DEN_W-1:0]             rem_next;
	logic [uerg_pkg::VAR_W-1:0]   var_res;
	logic                         near;
	logic                         full_now;

	// Wrap the elapsed time, then saturate
	assign elapsed = time_us - start_q;
	assign dt_sat  = (elapsed > {{(uerg_pkg::TIME_W - uerg_pkg::DT_W){1'b0}}, uerg_pkg::DT_MAX})
		? uerg_pkg::DT_MAX : elapsed[uerg_pkg::DT_W-1:0];

	assign full_now = (cnt_q == CNT_W'(HISTORY_DEPTH));

	// One restoring division step
	assign trial    = {rem_q, num_q[NUM_W-1]};
	assign trial_ge = (trial >= {1'b0, den_q});
	always_comb begin
		if (trial_ge) begin
			rem_next = DEN_W'(trial - {1'b0, den_q});
		end else begin
			rem_next = trial[DEN_W-1:0];
		end
	end

	// Result of the gate
	assign var_res = var_zero_q ? '0 : num_q[uerg_pkg::VAR_W-1:0];
	assign near    = (dist_q < min_dist_q);

	assign in_ready = (state_q == S_IDLE);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_dist_q  <= uerg_pkg::MIN_DIST_RST;
			var_limit_q <= uerg_pkg::VAR_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (uerg_pkg::cfg_idx_t'(cfg_index))
				uerg_pkg::CFG_MIN_DISTANCE:   min_dist_q  <= cfg_data[uerg_pkg::DIST_W-1:0];
				uerg_pkg::CFG_VARIANCE_LIMIT: var_limit_q <= cfg_data[uerg_pkg::VAR_W-1:0];
				default: ;
			endcase
		end
	end

	// History memory: read the slot about to be overwritten, write the new sample
	always_ff @(posedge clk) begin
		if (state_q == S_DIST) begin
			old_q <= hist_mem[wr_ptr_q];
		end
		if (state_q == S_UPD2) begin
			hist_mem[wr_ptr_q] <= dist_q;
		end
	end

	// Datapath registers without reset
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: dt_q <= dt_sat;
			S_MUL1: prod1_q <= dt_q * uerg_pkg::DIST_MUL;
			S_MUL2: prod2_q <= uerg_pkg::PROD2_W'(prod1_q) * uerg_pkg::DIST_RECIP;
			S_DIST: dist_q <= prod2_q[uerg_pkg::RECIP_SHIFT +: uerg_pkg::DIST_W];
			S_UPD1: begin
				new_sq_q <= dist_q * dist_q;
				old_sq_q <= old_q * old_q;
			end
			S_MULN: begin
				n_sq_q <= NUM_W'(cnt_q) * NUM_W'(sq_q);
				s_sq_q <= NUM_W'(sum_q) * NUM_W'(sum_q);
			end
			S_PREP: begin
				num_q <= n_sq_q - s_sq_q;
				den_q <= DEN_W'(cnt_q) * DEN_W'(cnt_q - CNT_W'(1));
				rem_q <= '0;
			end
			S_DIV: begin
				rem_q <= rem_next;
				num_q <= {num_q[NUM_W-2:0], trial_ge};
			end
			default: ;
		endcase
	end

	// Control state, ring bookkeeping and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			start_q      <= '0;
			wr_ptr_q     <= '0;
			cnt_q        <= '0;
			sum_q        <= '0;
			sq_q         <= '0;
			full_q       <= 1'b0;
			div_cnt_q    <= '0;
			var_zero_q   <= 1'b0;
			out_valid    <= 1'b0;
			distance_q4  <= '0;
			variance_q8  <= '0;
			near_alert   <= 1'b0;
			near_ignored <= 1'b0;
		end else begin
			// Drop the result once transferred
			if (out_valid && out_ready && (state_q != S_OUT)) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (echo_level) begin
							start_q <= time_us;
						end else begin
							state_q <= S_MUL1;
						end
					end
				end
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: state_q <= S_DIST;
				S_DIST: state_q <= S_UPD1;
				S_UPD1: begin
					// Remove the oldest sample from the sum when the ring is full
					full_q <= full_now;
					if (full_now) begin
						sum_q <= sum_q - SUM_W'(old_q) + SUM_W'(dist_q);
					end else begin
						sum_q <= sum_q + SUM_W'(dist_q);
						cnt_q <= cnt_q + CNT_W'(1);
					end
					state_q <= S_UPD2;
				end
				S_UPD2: begin
					if (full_q) begin
						sq_q <= sq_q - SQ_W'(old_sq_q) + SQ_W'(new_sq_q);
					end else begin
						sq_q <= sq_q + SQ_W'(new_sq_q);
					end
					if (wr_ptr_q == PTR_W'(HISTORY_DEPTH - 1)) begin
						wr_ptr_q <= '0;
					end else begin
						wr_ptr_q <= wr_ptr_q + PTR_W'(1);
					end
					state_q <= S_MULN;
				end
				S_MULN: state_q <= S_PREP;
				S_PREP: begin
					var_zero_q <= (cnt_q < CNT_W'(2));
					div_cnt_q  <= DCNT_W'(NUM_W - 1);
					state_q    <= S_DIV;
				end
				S_DIV: begin
					if (div_cnt_q == '0) begin
						state_q <= S_OUT;
					end else begin
						div_cnt_q <= div_cnt_q - DCNT_W'(1);
					end
				end
				S_OUT: begin
					// Load the result once the output register is free
					if (!out_valid || out_ready) begin
						out_valid    <= 1'b1;
						distance_q4  <= dist_q;
						variance_q8  <= var_res;
						near_alert   <= near && (var_res < var_limit_q);
						near_ignored <= near && (var_res >= var_limit_q);
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(HISTORY_DEPTH))
		else $error("sample count exceeds ring depth");

	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wr_ptr_q < PTR_W'(HISTORY_DEPTH))
		else $error("write pointer outside ring");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(near_alert && near_ignored))
		else $error("alert and ignored flags both set");

	a_empty_sums: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> (sum_q == '0 && sq_q == '0))
		else $error("running sums nonzero with empty ring");

	a_upd_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPD2) |-> (cnt_q != '0))
		else $error("ring count zero after a sample write");

endmodule
